[rtl/scs_pkg.sv]
// Shared types, widths and codes of the shadow call stack checker.
package scs_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam int KIND_W     = 2;
  localparam int PID_W      = 22;
  localparam int UID_W      = 32;
  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 64;
  localparam int RES_W      = 3;
  localparam int NEST_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_SYSCALL = 2'd0;
  localparam kind_t KIND_CALL    = 2'd1;
  localparam kind_t KIND_RETURN  = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  typedef logic [RES_W-1:0] res_t;
  localparam res_t RES_CALLED    = 3'd0;
  localparam res_t RES_VIRTUAL   = 3'd1;
  localparam res_t RES_RETURNED  = 3'd2;
  localparam res_t RES_UNMATCHED = 3'd3;
  localparam res_t RES_ARMED     = 3'd4;
  localparam res_t RES_BUDGET    = 3'd5;
  localparam res_t RES_FAULT     = 3'd6;
  localparam res_t RES_OVERFLOW  = 3'd7;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROOT_PID    = 2'd0;
  localparam cfg_idx_t CFG_BEGIN_COUNT = 2'd1;
  localparam cfg_idx_t CFG_END_COUNT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_RD,
    ST_BUDGET
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    res_t res;
    logic last;
    logic push;
    logic pop;
    logic set_armed;
    logic set_halted;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              halted;
    logic              armed;
    kind_t             kind;
    logic              pid_match;
    logic              level_zero;
    logic              level_full;
    logic              count_zero;
    logic              begin_hit;
    logic              over_end;
    logic              top_match;
    logic              out_free;
    logic [NEST_W-1:0] level;
  } sts_t;

endpackage

[rtl/scs_if.sv]
// Valid/ready channel interfaces for trace events and checker results.
interface scs_in_if;
  logic                         valid;
  logic                         ready;
  logic [scs_pkg::KIND_W-1:0]   kind;
  logic [scs_pkg::PID_W-1:0]    proc_id;
  logic [scs_pkg::UID_W-1:0]    user_id;
  logic [scs_pkg::ADDR_W-1:0]   func_start;
  logic [scs_pkg::CNT_W-1:0]    branch_count;

  modport source (output valid, kind, proc_id, user_id, func_start, branch_count,
                  input ready);
  modport sink (input valid, kind, proc_id, user_id, func_start, branch_count,
                output ready);
endinterface

interface scs_out_if;
  logic                         valid;
  logic                         ready;
  logic [scs_pkg::RES_W-1:0]    event_res;
  logic [scs_pkg::ADDR_W-1:0]   address;
  logic [scs_pkg::NEST_W-1:0]   nesting;
  logic [scs_pkg::UID_W-1:0]    echo_uid;
  logic                         last;

  modport source (output valid, event_res, address, nesting, echo_uid, last,
                  input ready);
  modport sink (input valid, event_res, address, nesting, echo_uid, last,
                output ready);
endinterface

[rtl/scs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/scs_dp.sv]
// Datapath: config registers, latched event, stack level, stack RAM, result register.
module scs_dp #(
  parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [scs_pkg::KIND_W-1:0]      in_kind,
  input  logic [scs_pkg::PID_W-1:0]       in_proc_id,
  input  logic [scs_pkg::UID_W-1:0]       in_user_id,
  input  logic [scs_pkg::ADDR_W-1:0]      in_func_start,
  input  logic [scs_pkg::CNT_W-1:0]       in_branch_count,
  input  scs_pkg::cmd_t                   cmd,
  output scs_pkg::sts_t                   sts,
  scs_out_if.source                       out_chan
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  logic [scs_pkg::PID_W-1:0]  root_pid_r;
  logic [scs_pkg::CNT_W-1:0]  begin_count_r;
  logic [scs_pkg::CNT_W-1:0]  end_count_r;

  scs_pkg::kind_t             kind_r;
  logic [scs_pkg::PID_W-1:0]  pid_r;
  logic [scs_pkg::UID_W-1:0]  uid_r;
  logic [scs_pkg::ADDR_W-1:0] fstart_r;
  logic [scs_pkg::CNT_W-1:0]  count_r;

  logic [LVL_W-1:0] level_r, level_nxt, level_dec;
  logic             armed_r, halted_r;

  logic [scs_pkg::ADDR_W-1:0] top_word;

  logic                        out_valid_r;
  scs_pkg::res_t               res_r;
  logic [scs_pkg::ADDR_W-1:0]  addr_r;
  logic [scs_pkg::NEST_W-1:0]  nest_r;
  logic [scs_pkg::UID_W-1:0]   euid_r;
  logic                        last_r;

  logic [scs_pkg::ADDR_W-1:0]  addr_nxt;
  logic [scs_pkg::NEST_W-1:0]  nest_nxt;
  logic [scs_pkg::UID_W-1:0]   euid_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_pid_r    <= '0;
      begin_count_r <= '0;
      end_count_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scs_pkg::CFG_ROOT_PID:    root_pid_r    <= cfg_wdata[scs_pkg::PID_W-1:0];
        scs_pkg::CFG_BEGIN_COUNT: begin_count_r <= cfg_wdata;
        scs_pkg::CFG_END_COUNT:   end_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latched event word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      pid_r    <= in_proc_id;
      uid_r    <= in_user_id;
      fstart_r <= in_func_start;
      count_r  <= in_branch_count;
    end
  end

  assign level_dec = level_r - LVL_W'(1);

  always_comb begin
    level_nxt = level_r;
    if (cmd.push) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (cmd.pop) begin
      level_nxt = level_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      armed_r  <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      level_r <= level_nxt;
      if (cmd.set_armed) begin
        armed_r <= 1'b1;
      end
      if (cmd.set_halted) begin
        halted_r <= 1'b1;
      end
    end
  end

  scs_ram #(
    .WIDTH (scs_pkg::ADDR_W),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (level_r[AW-1:0]),
    .wdata (fstart_r),
    .re    (cmd.pop),
    .raddr (level_dec[AW-1:0]),
    .rdata (top_word)
  );

  // result fields follow from the result code
  always_comb begin
    addr_nxt = fstart_r;
    nest_nxt = scs_pkg::NEST_W'(level_r);
    euid_nxt = '0;
    unique case (cmd.res)
      scs_pkg::RES_CALLED, scs_pkg::RES_RETURNED: euid_nxt = uid_r;
      scs_pkg::RES_VIRTUAL: addr_nxt = top_word;
      scs_pkg::RES_ARMED, scs_pkg::RES_FAULT: begin
        addr_nxt = '0;
        nest_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_r  <= cmd.res;
      addr_r <= addr_nxt;
      nest_r <= nest_nxt;
      euid_r <= euid_nxt;
      last_r <= cmd.last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.event_res = res_r;
  assign out_chan.address   = addr_r;
  assign out_chan.nesting   = nest_r;
  assign out_chan.echo_uid  = euid_r;
  assign out_chan.last      = last_r;

  always_comb begin
    sts.halted     = halted_r;
    sts.armed      = armed_r;
    sts.kind       = kind_r;
    sts.pid_match  = (pid_r == root_pid_r);
    sts.level_zero = (level_r == '0);
    sts.level_full = (level_r >= LVL_W'(STACK_DEPTH));
    sts.count_zero = (count_r == '0);
    sts.begin_hit  = (count_r == begin_count_r);
    sts.over_end   = (count_r > end_count_r);
    sts.top_match  = (top_word == fstart_r);
    sts.out_free   = !out_valid_r || out_chan.ready;
    sts.level      = scs_pkg::NEST_W'(level_r);
  end

endmodule

[rtl/scs_ctrl.sv]
// Controller: sequences decode, stack walk and result emission for one event.
module scs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  scs_pkg::sts_t sts,
  output scs_pkg::cmd_t cmd
);

  scs_pkg::state_t state_r, state_nxt;

  // decode of a freshly latched event
  logic          dec_emit, dec_last, dec_push, dec_arm, dec_halt, dec_walk;
  scs_pkg::res_t dec_res;

  always_comb begin
    dec_emit = 1'b0;
    dec_last = 1'b1;
    dec_push = 1'b0;
    dec_arm  = 1'b0;
    dec_halt = 1'b0;
    dec_walk = 1'b0;
    dec_res  = scs_pkg::RES_FAULT;
    priority if (sts.halted || sts.kind == scs_pkg::KIND_NONE) begin
    end else if (sts.count_zero) begin
      dec_emit = 1'b1;
    end else begin
      unique case (sts.kind)
        scs_pkg::KIND_SYSCALL: begin
          if (sts.begin_hit) begin
            dec_emit = 1'b1;
            dec_arm  = 1'b1;
            dec_res  = scs_pkg::RES_ARMED;
          end
        end
        scs_pkg::KIND_CALL: begin
          if (sts.armed && sts.pid_match) begin
            dec_emit = 1'b1;
            if (sts.level_full) begin
              dec_res  = scs_pkg::RES_OVERFLOW;
              dec_halt = 1'b1;
            end else begin
              dec_res  = scs_pkg::RES_CALLED;
              dec_push = 1'b1;
            end
          end
        end
        scs_pkg::KIND_RETURN: begin
          if (sts.armed) begin
            if (sts.pid_match) begin
              dec_walk = 1'b1;
            end else if (sts.over_end) begin
              dec_emit = 1'b1;
              dec_halt = 1'b1;
              dec_res  = scs_pkg::RES_BUDGET;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = scs_pkg::ST_DECIDE;
        end
      end
      scs_pkg::ST_DECIDE: begin
        if (dec_walk) begin
          state_nxt = scs_pkg::ST_POP;
        end else if (!dec_emit || sts.out_free) begin
          state_nxt = scs_pkg::ST_IDLE;
        end
      end
      scs_pkg::ST_POP: begin
        if (!sts.level_zero) begin
          state_nxt = scs_pkg::ST_RD;
        end else if (sts.out_free) begin
          state_nxt = scs_pkg::ST_IDLE;
        end
      end
      scs_pkg::ST_RD: begin
        if (sts.out_free) begin
          if (!sts.top_match) begin
            state_nxt = scs_pkg::ST_POP;
          end else if (sts.over_end) begin
            state_nxt = scs_pkg::ST_BUDGET;
          end else begin
            state_nxt = scs_pkg::ST_IDLE;
          end
        end
      end
      scs_pkg::ST_BUDGET: begin
        if (sts.out_free) begin
          state_nxt = scs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      scs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      scs_pkg::ST_DECIDE: begin
        if (dec_emit && sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.res        = dec_res;
          cmd.last       = dec_last;
          cmd.push       = dec_push;
          cmd.set_armed  = dec_arm;
          cmd.set_halted = dec_halt;
        end
      end
      scs_pkg::ST_POP: begin
        if (!sts.level_zero) begin
          cmd.pop = 1'b1;
        end else if (sts.out_free) begin
          // stack ran dry without a match
          cmd.emit       = 1'b1;
          cmd.res        = scs_pkg::RES_UNMATCHED;
          cmd.last       = 1'b1;
          cmd.set_halted = 1'b1;
        end
      end
      scs_pkg::ST_RD: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.top_match) begin
            cmd.res  = scs_pkg::RES_RETURNED;
            cmd.last = !sts.over_end;
          end else begin
            cmd.res  = scs_pkg::RES_VIRTUAL;
            cmd.last = 1'b0;
          end
        end
      end
      scs_pkg::ST_BUDGET: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.res        = scs_pkg::RES_BUDGET;
          cmd.last       = 1'b1;
          cmd.set_halted = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/shadow_call_stack_checker.sv]
// Top level of the shadow call stack checker: controller, datapath and assertions.
// One trace event at a time. An event is taken in IDLE and decided in the next cycle,
// in DECIDE, where a syscall entry, a call or an event that gives no stack walk ends.
// A tracked return walks the stack through the single read port of the stack RAM,
// whose read data is registered: each popped entry is read in POP and compared in RD.
// A walk that runs the stack dry without a match ends with a result from POP; a match
// over the branch budget is followed by a further result from BUDGET. The result
// register lets the next event be taken while the last result is still waiting; a
// result that cannot be placed stalls the walk. After a halt, events are still taken
// but give no results until reset.
module shadow_call_stack_checker #(
  parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  scs_in_if.sink                          in_chan,
  scs_out_if.source                       out_chan
);

  scs_pkg::cmd_t cmd;
  scs_pkg::sts_t sts;
  logic          ctrl_in_ready;

  assign in_chan.ready = ctrl_in_ready;

  scs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_chan.kind),
    .in_proc_id      (in_chan.proc_id),
    .in_user_id      (in_chan.user_id),
    .in_func_start   (in_chan.func_start),
    .in_branch_count (in_chan.branch_count),
    .cmd             (cmd),
    .sts             (sts),
    .out_chan        (out_chan)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.level <= scs_pkg::NEST_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.halted |=> sts.halted)
    else $error("halt cleared without reset");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result written over a waiting word");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.level_full && !cmd.pop)
    else $error("push onto a full stack");

endmodule
